FILE: rtl/arpc_pkg.sv
// arpc_pkg: shared types and constants for the age/reuse priority cache lookup
// no dependencies
`timescale 1ns / 1ps
package arpc_pkg;
  localparam int TAG_W = 30;
  localparam int AGE_W = 3;
  localparam int CNT_W = 8;
  localparam int WAYS  = 4;
  localparam int WAY_W = 2;

  localparam logic [1:0] REG_OFFSET = 2'd0;
  localparam logic [1:0] REG_INDEX  = 2'd1;
  localparam logic [1:0] REG_PRIO   = 2'd2;

  typedef struct packed {
    logic start;
    logic clear;
    logic read;
    logic update;
  } arpc_cmd_t;

  typedef struct packed {
    logic clear_done;
  } arpc_stat_t;

  typedef struct packed {
    logic             valid;
    logic             reused;
    logic [AGE_W-1:0] age;
    logic [TAG_W-1:0] tag;
  } arpc_line_t;
endpackage

FILE: rtl/arpc_datapath.sv
// arpc_datapath: set memory, tag compare, victim choice and ageing
// depends on arpc_pkg
`timescale 1ns / 1ps
module arpc_datapath import arpc_pkg::*; #(
  parameter int SETS = 4096,
  parameter int AGE_PERIOD = 16,
  parameter int MAX_AGE = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  arpc_cmd_t              cmd,
  output arpc_stat_t             stat,
  input  logic [3:0]             offset_bits,
  input  logic [3:0]             index_bits,
  input  logic [63:0]            priority_table,
  input  logic [31:0]            address,
  output logic                   hit,
  output logic [WAY_W-1:0]       way,
  output logic [AGE_W-1:0]       hit_age,
  output logic                   hit_was_reused,
  output logic                   victim_valid,
  output logic [TAG_W-1:0]       victim_tag
);
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int ROW_W = WAYS * (2 + AGE_W + TAG_W) + CNT_W;
  localparam int RCP_SH = 24;
  localparam logic [24:0] RCP = 25'(((64'd1 << RCP_SH) + 64'(SETS) - 64'd1) / 64'(SETS));

  logic [ROW_W-1:0] mem [SETS];
  logic [ROW_W-1:0] rdata;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic [SET_W-1:0] clr_idx;

  logic [3:0] off, ib;
  logic [31:0] shifted;
  logic [11:0] set_full;
  logic [36:0] set_prod;
  logic [11:0] set_quo;
  logic [23:0] set_back;
  logic [11:0] set_rem;
  logic [SET_W-1:0] set_c;
  logic [TAG_W-1:0] tag_c;
  logic [4:0] tsh;

  // set number reduced modulo SETS by reciprocal multiplication
  always_comb begin
    off = (offset_bits < 4'd2) ? 4'd2 : ((offset_bits > 4'd12) ? 4'd12 : offset_bits);
    ib = (index_bits > 4'd12) ? 4'd12 : index_bits;
    shifted = address >> off;
    set_full = shifted[11:0] & ((12'd1 << ib) - 12'd1);
    set_prod = 37'(set_full) * 37'(RCP);
    set_quo = set_prod[35:24];
    set_back = 24'(set_quo) * 24'(SETS);
    set_rem = set_full - set_back[11:0];
    set_c = SET_W'(set_rem);
    tsh = 5'(off) + 5'(ib);
    tag_c = TAG_W'(address >> tsh);
  end

  arpc_line_t ln [WAYS];
  logic [CNT_W-1:0] cnt;
  always_comb begin
    for (int w = 0; w < WAYS; w++)
      ln[w] = rdata[w*(2+AGE_W+TAG_W) +: (2+AGE_W+TAG_W)];
    cnt = rdata[ROW_W-1 -: CNT_W];
  end

  logic hit_c;
  logic [WAY_W-1:0] sel;
  logic [3:0] best;
  logic [3:0] k;
  logic [3:0] p;
  arpc_line_t nl [WAYS];
  logic [CNT_W-1:0] ncnt;
  logic [ROW_W-1:0] wrow;

  always_comb begin
    hit_c = 1'b0;
    sel = '0;
    k = '0;
    p = '0;
    for (int w = WAYS-1; w >= 0; w--)
      if (ln[w].valid && ln[w].tag == tag_q) begin
        hit_c = 1'b1;
        sel = WAY_W'(w);
      end
    best = '0;
    if (!hit_c) begin
      for (int w = 0; w < WAYS; w++) begin
        k = {ln[w].age, ~ln[w].reused};
        p = priority_table[{k, 2'b00} +: 4];
        if (w == 0 || p > best) begin
          best = p;
          sel = WAY_W'(w);
        end
      end
    end
    for (int w = 0; w < WAYS; w++) nl[w] = ln[w];
    nl[sel].valid = 1'b1;
    nl[sel].reused = hit_c;
    nl[sel].age = '0;
    if (!hit_c) nl[sel].tag = tag_q;
    if (32'(cnt) + 32'd1 >= AGE_PERIOD) begin
      ncnt = '0;
      for (int w = 0; w < WAYS; w++)
        if (32'(nl[w].age) < MAX_AGE) nl[w].age = nl[w].age + AGE_W'(1);
    end else begin
      ncnt = cnt + CNT_W'(1);
    end
    for (int w = 0; w < WAYS; w++) wrow[w*(2+AGE_W+TAG_W) +: (2+AGE_W+TAG_W)] = nl[w];
    wrow[ROW_W-1 -: CNT_W] = ncnt;
  end

  arpc_line_t rst_row [WAYS];
  logic [ROW_W-1:0] clr_row;
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rst_row[w].valid = 1'b0;
      rst_row[w].reused = 1'b0;
      rst_row[w].age = AGE_W'(w);
      rst_row[w].tag = '0;
      clr_row[w*(2+AGE_W+TAG_W) +: (2+AGE_W+TAG_W)] = rst_row[w];
    end
    clr_row[ROW_W-1 -: CNT_W] = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) mem[clr_idx] <= clr_row;
    else if (cmd.update) mem[set_q] <= wrow;
    if (cmd.read) rdata <= mem[set_q];
    if (cmd.start) begin
      set_q <= set_c;
      tag_q <= tag_c;
    end
    if (cmd.update) begin
      hit <= hit_c;
      way <= sel;
      hit_age <= hit_c ? ln[sel].age : '0;
      hit_was_reused <= hit_c ? ln[sel].reused : 1'b0;
      victim_valid <= !hit_c && ln[sel].valid;
      victim_tag <= (!hit_c && ln[sel].valid) ? ln[sel].tag : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) clr_idx <= '0;
    else if (cmd.clear && !stat.clear_done) clr_idx <= clr_idx + SET_W'(1);
  end
  assign stat.clear_done = (32'(clr_idx) == SETS - 1);
endmodule

FILE: rtl/arpc_ctrl.sv
// arpc_ctrl: sequencer for clearing pass, read, update and result hand-off
// depends on arpc_pkg
`timescale 1ns / 1ps
module arpc_ctrl import arpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output arpc_cmd_t  cmd,
  input  arpc_stat_t stat
);
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_UPD = 3'd3,
                         S_OUT = 3'd4;
  logic [2:0] state, state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_CLR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.start = in_valid;
        if (in_valid) state_next = S_RD;
      end
      S_RD: begin
        cmd.read = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else state <= state_next;
  end

  a_no_both: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output open together");
  a_start_rd: assert property (@(posedge clk) disable iff (rst) cmd.start |=> cmd.read)
    else $error("read did not follow start");
  a_rd_upd: assert property (@(posedge clk) disable iff (rst) cmd.read |=> cmd.update)
    else $error("update did not follow read");
  a_upd_out: assert property (@(posedge clk) disable iff (rst) cmd.update |=> out_valid)
    else $error("result not shown after update");
endmodule

FILE: rtl/age_reuse_priority_cache_lookup_top.sv
// age_reuse_priority_cache_lookup_top: four-way tag store with age/reuse replacement
// depends on arpc_pkg, arpc_ctrl, arpc_datapath
`timescale 1ns / 1ps
// Each item passes from acceptance to result through accept, set memory read,
// update and write-back, and a result held until taken; the next item is taken
// once the result is accepted. The single-port set memory read-then-write keeps
// items from overlapping. After reset a clearing pass initialises every set before
// the first item is taken; configuration writes are accepted throughout.
module age_reuse_priority_cache_lookup_top import arpc_pkg::*; #(
  parameter int SETS = 4096,
  parameter int AGE_PERIOD = 16,
  parameter int MAX_AGE = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [1:0]  way,
  output logic [2:0]  hit_age,
  output logic        hit_was_reused,
  output logic        victim_valid,
  output logic [29:0] victim_tag
);
  logic [3:0] offset_bits, index_bits;
  logic [63:0] priority_table;
  arpc_cmd_t cmd;
  arpc_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= 4'd4;
      index_bits <= 4'd9;
      priority_table <= 64'hFEDCBA9876543210;
    end else if (cfg_we) begin
      if (cfg_index == REG_OFFSET) offset_bits <= cfg_data[3:0];
      if (cfg_index == REG_INDEX) index_bits <= cfg_data[3:0];
      if (cfg_index == REG_PRIO) priority_table <= cfg_data;
    end
  end

  arpc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
  );

  arpc_datapath #(.SETS(SETS), .AGE_PERIOD(AGE_PERIOD), .MAX_AGE(MAX_AGE)) u_dp (
    .clk, .rst, .cmd, .stat, .offset_bits, .index_bits, .priority_table, .address,
    .hit, .way, .hit_age, .hit_was_reused, .victim_valid, .victim_tag
  );
endmodule
